@@ rtl/expiring_tag_hash_table_defines.svh @@
// ----------------------------------------------------------------------------
// Expiring tag hash table assertion macros
// Shared assertion helpers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EXPIRING_TAG_HASH_TABLE_DEFINES_SVH
`define EXPIRING_TAG_HASH_TABLE_DEFINES_SVH
`ifndef SYNTH
`define ETHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ETHT_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ETHT_ASSERT(label, prop, msg)
`define ETHT_ASSERT_RST(label, prop, msg)
`endif
`endif

@@ rtl/etht_pkg.sv @@
// ----------------------------------------------------------------------------
// Expiring tag hash table package
// Types, codes and the key hash shared by the front and back parts.
// ----------------------------------------------------------------------------
package etht_pkg;

    localparam int unsigned SlotsDefault    = 8192;
    localparam int unsigned MaxProbeDefault = 64;
    localparam logic [15:0] PruneReset      = 16'd90;
    localparam logic [31:0] HashMul         = 32'h7FEB352D;
    localparam int unsigned CountW          = 14;

    typedef enum logic [2:0] {
        KIND_FIND   = 3'd0,
        KIND_INSERT = 3'd1,
        KIND_ERASE  = 3'd2,
        KIND_UPDATE = 3'd3,
        KIND_CLEAR  = 3'd4,
        KIND_PRUNE  = 3'd5,
        KIND_NOP6   = 3'd6,
        KIND_NOP7   = 3'd7
    } kind_t;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_USED  = 2'd1,
        ST_DEAD  = 2'd2,
        ST_SPARE = 2'd3
    } slot_st_t;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISS    = 2'd1;
    localparam logic [1:0] STAT_DROPPED = 2'd2;
    localparam logic [1:0] STAT_SKIPPED = 2'd3;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] key;
        logic [31:0] expiry;
        logic [7:0]  tag;
        logic [31:0] now;
        logic [31:0] mixed;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              hit;
        logic [7:0]        found_tag;
        logic [31:0]       found_expiry;
        logic [CountW-1:0] entry_count;
    } res_t;

    function automatic logic [31:0] hash_pre(input logic [31:0] k);
        hash_pre = k ^ (k >> 16);
    endfunction

endpackage

@@ rtl/etht_front.sv @@
// ----------------------------------------------------------------------------
// Expiring tag hash table front part
// Accepts words, starts the hash multiply and queues commands for the back.
// ----------------------------------------------------------------------------
module etht_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [2:0]      in_kind,
    input  logic [31:0]     in_key,
    input  logic [31:0]     in_expiry,
    input  logic [7:0]      in_tag,
    input  logic [31:0]     in_now,
    output logic            q_valid,
    input  logic            q_ready,
    output etht_pkg::cmd_t  q_cmd
);
    import etht_pkg::*;

    cmd_t q0_reg, q0_next, q1_reg, q1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic acc, pop;
    cmd_t incoming;

    always_comb
    begin
        incoming.kind   = kind_t'(in_kind);
        incoming.key    = in_key;
        incoming.expiry = in_expiry;
        incoming.tag    = in_tag;
        incoming.now    = in_now;
        incoming.mixed  = hash_pre(in_key) * HashMul;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q0_reg;
    assign acc      = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb
    begin
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        cnt_next = cnt_reg;
        if (pop)
        begin
            q0_next = q1_reg;
        end
        if (acc)
        begin
            if (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop))
            begin
                q0_next = incoming;
            end
            else
            begin
                q1_next = incoming;
            end
        end
        cnt_next = cnt_reg + {1'b0, acc} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

`include "expiring_tag_hash_table_defines.svh"
    `ETHT_ASSERT_RST(a_cnt_range, (!rst_n || cnt_reg != 2'd3), "queue count out of range")
    `ETHT_ASSERT(a_no_acc_full, (cnt_reg == 2'd2 |-> !acc), "write into full queue")
    `ETHT_ASSERT(a_cnt_step, (acc && !pop |=> cnt_reg == $past(cnt_reg) + 2'd1),
        "queue count did not advance")
endmodule

@@ rtl/etht_back.sv @@
// ----------------------------------------------------------------------------
// Expiring tag hash table back part
// Probes the slot memories, applies each command and runs clear and prune.
// ----------------------------------------------------------------------------
module etht_back
#(
    parameter int unsigned SLOTS     = etht_pkg::SlotsDefault,
    parameter int unsigned MAX_PROBE = etht_pkg::MaxProbeDefault
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     prune_interval,
    input  logic            q_valid,
    output logic            q_ready,
    input  etht_pkg::cmd_t  q_cmd,
    output logic            res_valid,
    input  logic            res_ready,
    output etht_pkg::res_t  res
);
    import etht_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned PW = $clog2(MAX_PROBE + 1);
    localparam int unsigned UW = $clog2(SLOTS + 1);
    localparam bit          POW2 = (SLOTS == (1 << AW));
    localparam logic [31:0] SLOTS32 = 32'(SLOTS);
    localparam logic [31:0] RECIP = 32'((64'd1 << (31 + AW)) / 64'(SLOTS));

    typedef enum logic [11:0] {
        S_INIT   = 12'b000000000001,
        S_IDLE   = 12'b000000000010,
        S_HASH   = 12'b000000000100,
        S_RD     = 12'b000000001000,
        S_CHK    = 12'b000000010000,
        S_CLR    = 12'b000000100000,
        S_SCAN   = 12'b000001000000,
        S_SCHK   = 12'b000010000000,
        S_RFETCH = 12'b000100000000,
        S_RWAIT  = 12'b001000000000,
        S_OUT    = 12'b010000000000,
        S_WAITO  = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]  mem_st   [SLOTS];
    logic [31:0] mem_key  [SLOTS];
    logic [31:0] mem_exp  [SLOTS];
    logic [7:0]  mem_tag  [SLOTS];
    logic [31:0] sv_key   [SLOTS];
    logic [31:0] sv_exp   [SLOTS];
    logic [7:0]  sv_tag   [SLOTS];

    logic [1:0]  rd_st;
    logic [31:0] rd_key, rd_exp, rd_sk, rd_se;
    logic [7:0]  rd_tag, rd_st8;

    logic [AW-1:0] addr_reg, addr_next, home;
    logic [AW-1:0] free_reg, free_next;
    logic          have_free_reg, have_free_next;
    logic [PW-1:0] n_reg, n_next;
    logic [AW:0]   scnt_reg, scnt_next, sidx_reg, sidx_next;
    logic          reins_reg, reins_next;
    logic [UW-1:0] used_reg, used_next;
    logic [31:0]   lpt_reg, lpt_next;
    cmd_t          cmd_reg, cmd_next;
    res_t          res_reg, res_next;
    logic [31:0]   hfull;
    logic [63:0]   prod;
    logic [31:0]   qe_reg, qe_next, qs, rem_reg, rem_next, rem_fix;
    logic [1:0]    hstep_reg, hstep_next;

    logic          we_st;
    logic [AW-1:0] wa;
    logic [1:0]    wd_st;
    logic          we_kv, we_e, we_sv;
    logic [31:0]   wd_e;
    logic [AW-1:0] ra;
    logic [AW-1:0] sra;
    logic [AW-1:0] swa;

    // For a table size that is not a power of two the home slot is reduced in
    // registered steps: a reciprocal multiply, then a back multiply and subtract,
    // then one final correction.
    assign hfull    = cmd_reg.mixed ^ (cmd_reg.mixed >> 15);
    assign prod     = {32'd0, hfull} * {32'd0, RECIP};
    assign qe_next  = 32'(prod >> (31 + AW));
    assign qs       = qe_reg * SLOTS32;
    assign rem_next = hfull - qs;
    assign rem_fix  = (rem_reg >= SLOTS32) ? rem_reg - SLOTS32 : rem_reg;

    always_comb
    begin
        if (POW2)
        begin
            home = hfull[AW-1:0];
        end
        else
        begin
            home = rem_fix[AW-1:0];
        end
    end

    function automatic logic [AW-1:0] nxt(input logic [AW-1:0] a);
        nxt = (32'(a) == SLOTS - 1) ? '0 : a + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (we_st)
        begin
            mem_st[wa] <= wd_st;
        end
        rd_st <= mem_st[ra];
    end

    always_ff @(posedge clk)
    begin
        if (we_kv)
        begin
            mem_key[wa] <= cmd_reg.key;
            mem_tag[wa] <= cmd_reg.tag;
        end
        if (we_e)
        begin
            mem_exp[wa] <= wd_e;
        end
        rd_key <= mem_key[ra];
        rd_exp <= mem_exp[ra];
        rd_tag <= mem_tag[ra];
    end

    always_ff @(posedge clk)
    begin
        if (we_sv)
        begin
            sv_key[swa] <= rd_key;
            sv_exp[swa] <= rd_exp;
            sv_tag[swa] <= rd_tag;
        end
        rd_sk  <= sv_key[sra];
        rd_se  <= sv_exp[sra];
        rd_st8 <= sv_tag[sra];
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_WAITO);
    assign res       = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        free_next      = free_reg;
        have_free_next = have_free_reg;
        n_next         = n_reg;
        scnt_next      = scnt_reg;
        sidx_next      = sidx_reg;
        reins_next     = reins_reg;
        used_next      = used_reg;
        lpt_next       = lpt_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        hstep_next     = hstep_reg;
        we_st = 1'b0;
        we_kv = 1'b0;
        we_e  = 1'b0;
        we_sv = 1'b0;
        wa    = addr_reg;
        wd_st = ST_EMPTY;
        wd_e  = cmd_reg.expiry;
        ra    = addr_reg;
        sra   = sidx_reg[AW-1:0];
        swa   = scnt_reg[AW-1:0];
        case (state_reg)
            S_INIT:
            begin
                we_st = 1'b1;
                addr_next = nxt(addr_reg);
                if (32'(addr_reg) == SLOTS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    cmd_next = q_cmd;
                    res_next = '0;
                    case (q_cmd.kind)
                        KIND_FIND, KIND_INSERT, KIND_ERASE, KIND_UPDATE:
                        begin
                            reins_next = 1'b0;
                            state_next = S_HASH;
                        end
                        KIND_CLEAR:
                        begin
                            addr_next  = '0;
                            reins_next = 1'b0;
                            state_next = S_CLR;
                        end
                        KIND_PRUNE:
                        begin
                            if ((q_cmd.now - lpt_reg) < {16'd0, prune_interval})
                            begin
                                res_next.status = STAT_SKIPPED;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                lpt_next   = q_cmd.now;
                                addr_next  = '0;
                                scnt_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                if (POW2 || hstep_reg == 2'd2)
                begin
                    addr_next      = home;
                    n_next         = '0;
                    have_free_next = 1'b0;
                    hstep_next     = '0;
                    state_next     = S_RD;
                end
                else
                begin
                    hstep_next = hstep_reg + 2'd1;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_CHK:
            begin
                state_next = S_OUT;
                if (cmd_reg.kind == KIND_INSERT)
                begin
                    if (rd_st == ST_USED && rd_key == cmd_reg.key)
                    begin
                        we_kv = 1'b1;
                        we_e  = 1'b1;
                        res_next.hit = 1'b1;
                        res_next.found_tag = cmd_reg.tag;
                        res_next.found_expiry = cmd_reg.expiry;
                    end
                    else if (rd_st == ST_EMPTY || 32'(n_reg) == MAX_PROBE - 1)
                    begin
                        if (have_free_reg || rd_st != ST_USED)
                        begin
                            wa = (have_free_reg) ? free_reg : addr_reg;
                            we_kv = 1'b1;
                            we_e  = 1'b1;
                            we_st = 1'b1;
                            wd_st = ST_USED;
                            used_next = used_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.status = STAT_DROPPED;
                        end
                    end
                    else
                    begin
                        if (rd_st != ST_USED && !have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_next      = addr_reg;
                        end
                        addr_next  = nxt(addr_reg);
                        n_next     = n_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                else
                begin
                    if (rd_st == ST_USED && rd_key == cmd_reg.key)
                    begin
                        res_next.hit = 1'b1;
                        res_next.found_tag = rd_tag;
                        res_next.found_expiry = rd_exp;
                        if (cmd_reg.kind == KIND_ERASE)
                        begin
                            we_st = 1'b1;
                            wd_st = ST_DEAD;
                            if (used_reg != '0)
                            begin
                                used_next = used_reg - 1'b1;
                            end
                        end
                        else if (cmd_reg.kind == KIND_UPDATE)
                        begin
                            we_e = 1'b1;
                            res_next.found_expiry = cmd_reg.expiry;
                        end
                    end
                    else if (rd_st == ST_EMPTY || 32'(n_reg) == MAX_PROBE - 1)
                    begin
                        res_next.status = STAT_MISS;
                    end
                    else
                    begin
                        addr_next  = nxt(addr_reg);
                        n_next     = n_reg + 1'b1;
                        state_next = S_RD;
                    end
                end
                if (reins_reg && state_next == S_OUT)
                begin
                    res_next   = '0;
                    state_next = S_RFETCH;
                end
            end
            S_CLR:
            begin
                we_st = 1'b1;
                addr_next = nxt(addr_reg);
                if (32'(addr_reg) == SLOTS - 1)
                begin
                    used_next = '0;
                    if (reins_reg)
                    begin
                        sidx_next  = '0;
                        state_next = S_RFETCH;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (rd_st == ST_USED && cmd_reg.now <= rd_exp)
                begin
                    we_sv = 1'b1;
                    scnt_next = scnt_reg + 1'b1;
                end
                if (32'(addr_reg) == SLOTS - 1)
                begin
                    addr_next  = '0;
                    reins_next = 1'b1;
                    state_next = S_CLR;
                end
                else
                begin
                    addr_next  = nxt(addr_reg);
                    state_next = S_SCAN;
                end
            end
            S_RFETCH:
            begin
                if (sidx_reg == scnt_reg)
                begin
                    reins_next = 1'b0;
                    res_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_RWAIT;
                end
            end
            S_RWAIT:
            begin
                cmd_next.kind   = KIND_INSERT;
                cmd_next.key    = rd_sk;
                cmd_next.expiry = rd_se;
                cmd_next.tag    = rd_st8;
                cmd_next.mixed  = hash_pre(rd_sk) * HashMul;
                sidx_next       = sidx_reg + 1'b1;
                state_next      = S_HASH;
            end
            S_OUT:
            begin
                res_next.entry_count = CountW'(used_reg);
                state_next = S_WAITO;
            end
            S_WAITO:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
            used_reg  <= '0;
            lpt_reg   <= '0;
            reins_reg <= 1'b0;
            hstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            used_reg  <= used_next;
            lpt_reg   <= lpt_next;
            reins_reg <= reins_next;
            hstep_reg <= hstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_reg      <= free_next;
        have_free_reg <= have_free_next;
        n_reg         <= n_next;
        scnt_reg      <= scnt_next;
        sidx_reg      <= sidx_next;
        cmd_reg       <= cmd_next;
        res_reg       <= res_next;
        qe_reg        <= qe_next;
        rem_reg       <= rem_next;
    end

`include "expiring_tag_hash_table_defines.svh"
    `ETHT_ASSERT_RST(a_onehot, (!rst_n || $onehot(state_reg)), "state not one-hot")
    `ETHT_ASSERT(a_res_hold, (res_valid && !res_ready |=> res_valid && $stable(res_reg)),
        "result changed while stalled")
    `ETHT_ASSERT(a_used_max, (32'(used_reg) <= SLOTS), "used count beyond table size")
    `ETHT_ASSERT(a_take_idle, (q_ready |-> !res_valid), "took command while result pending")
endmodule

@@ rtl/expiring_tag_hash_table.sv @@
// ----------------------------------------------------------------------------
// Expiring tag hash table
// Open-addressed hash table with tombstones, bounded linear probing and prune.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         kind (tuser); key, expiry, tag, now (tdata)
// m_axis    out        status, hit, found_tag, found_expiry, entry_count
// cfg       in         prune_interval
//
// A lookup takes the word, reduces the key to its home slot, reads the slot memories
// through a registered read and checks the slot; each extra probe slot repeats the read
// and check, and a table size that is not a power of two adds the registered home slot
// reduction. Clear writes every slot once; prune scans every slot, clears the table and
// reinserts each survivor. After reset a clearing pass over every slot runs before the
// back part takes the first word. A two-word queue lets the input side run ahead
// while the back part is busy or the output stalls.
// ----------------------------------------------------------------------------
module expiring_tag_hash_table
#(
    parameter int unsigned SLOTS     = etht_pkg::SlotsDefault,
    parameter int unsigned MAX_PROBE = etht_pkg::MaxProbeDefault
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // key[31:0], expiry[63:32], tag[71:64], now[103:72]
    input  logic [103:0]  s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // status[1:0], hit[2], found_tag[10:3], found_expiry[42:11],
    // entry_count[56:43], zero fill
    output logic [63:0]   m_axis_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [15:0]   cfg_data
);
    import etht_pkg::*;

    logic        q_valid, q_ready;
    cmd_t        q_cmd;
    res_t        res;
    logic [15:0] interval_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= PruneReset;
        end
        else if (cfg_valid)
        begin
            interval_reg <= cfg_data;
        end
    end

    etht_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_key    (s_axis_tdata[31:0]),
        .in_expiry (s_axis_tdata[63:32]),
        .in_tag    (s_axis_tdata[71:64]),
        .in_now    (s_axis_tdata[103:72]),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd)
    );

    etht_back #(.SLOTS(SLOTS), .MAX_PROBE(MAX_PROBE)) u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .prune_interval (interval_reg),
        .q_valid        (q_valid),
        .q_ready        (q_ready),
        .q_cmd          (q_cmd),
        .res_valid      (m_axis_tvalid),
        .res_ready      (m_axis_tready),
        .res            (res)
    );

    assign m_axis_tdata = {7'd0, res.entry_count, res.found_expiry, res.found_tag,
                           res.hit, res.status};
endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Expiring tag hash table testbench
// Drives lookups, inserts, erases, expiry updates, clears and prunes into the
// table, keeps a shadow copy of the table and checks every result word.
// ----------------------------------------------------------------------------
module tb_top;
    import etht_pkg::*;

    localparam int unsigned TblSlots = 8192;
    localparam int unsigned ProbeMax = 64;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] key;
        logic [31:0] expiry;
        logic [7:0]  tag;
        logic [31:0] now;
    } op_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        hit;
        logic [7:0]  found_tag;
        logic [31:0] found_expiry;
        logic [13:0] entry_count;
    } answer_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data = '0;

    logic [31:0] shadow_key [TblSlots];
    logic [31:0] shadow_expiry [TblSlots];
    logic [7:0]  shadow_tag [TblSlots];
    logic [1:0]  shadow_state [TblSlots];
    logic [31:0] keep_key [$];
    logic [31:0] keep_expiry [$];
    logic [7:0]  keep_tag [$];
    int unsigned live_count;
    logic [31:0] last_prune;
    logic [15:0] interval_reg;

    answer_t     pending_answers [$];
    int unsigned mismatches;
    int unsigned burst_left;
    logic [31:0] clock_now;
    logic [31:0] key_pool [$];
    logic [31:0] chain_keys [$];
    logic [15:0] stall_cnt;

    expiring_tag_hash_table uut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned home_of(input logic [31:0] k);
        logic [31:0] h;
        h = k ^ (k >> 16);
        h = h * 32'h7FEB352D;
        h = h ^ (h >> 15);
        return h % TblSlots;
    endfunction

    function automatic int find_entry(input logic [31:0] k);
        int unsigned i;
        i = home_of(k);
        for (int n = 0; n < ProbeMax; n++)
        begin
            if (shadow_state[i] == ST_EMPTY)
                return -1;
            if (shadow_state[i] == ST_USED && shadow_key[i] == k)
                return i;
            i = (i + 1) % TblSlots;
        end
        return -1;
    endfunction

    // Returns 0 for a new entry, 1 for a replacement in place, 2 when dropped.
    function automatic int store_entry(input logic [31:0] k, input logic [31:0] e,
                                       input logic [7:0] t);
        int unsigned i;
        int          free_at;
        i = home_of(k);
        free_at = -1;
        for (int n = 0; n < ProbeMax; n++)
        begin
            if (shadow_state[i] == ST_USED && shadow_key[i] == k)
            begin
                shadow_expiry[i] = e;
                shadow_tag[i] = t;
                return 1;
            end
            if (shadow_state[i] != ST_USED && free_at < 0)
                free_at = i;
            if (shadow_state[i] == ST_EMPTY)
                break;
            i = (i + 1) % TblSlots;
        end
        if (free_at < 0)
            return 2;
        shadow_key[free_at] = k;
        shadow_expiry[free_at] = e;
        shadow_tag[free_at] = t;
        shadow_state[free_at] = ST_USED;
        live_count++;
        return 0;
    endfunction

    function automatic void empty_table();
        for (int i = 0; i < TblSlots; i++)
            shadow_state[i] = ST_EMPTY;
        live_count = 0;
    endfunction

    function automatic answer_t table_answer(input op_t op);
        answer_t a;
        int      s;
        int      r;
        a = '0;
        case (op.kind)
            KIND_FIND, KIND_ERASE, KIND_UPDATE:
            begin
                s = find_entry(op.key);
                if (s < 0)
                    a.status = STAT_MISS;
                else
                begin
                    a.hit = 1'b1;
                    a.found_tag = shadow_tag[s];
                    a.found_expiry = shadow_expiry[s];
                    if (op.kind == KIND_ERASE)
                    begin
                        shadow_state[s] = ST_DEAD;
                        if (live_count > 0)
                            live_count--;
                    end
                    else if (op.kind == KIND_UPDATE)
                    begin
                        shadow_expiry[s] = op.expiry;
                        a.found_expiry = op.expiry;
                    end
                end
            end
            KIND_INSERT:
            begin
                r = store_entry(op.key, op.expiry, op.tag);
                if (r == 2)
                    a.status = STAT_DROPPED;
                else if (r == 1)
                begin
                    a.hit = 1'b1;
                    a.found_tag = op.tag;
                    a.found_expiry = op.expiry;
                end
            end
            KIND_CLEAR:
                empty_table();
            KIND_PRUNE:
            begin
                if (32'(op.now - last_prune) < {16'd0, interval_reg})
                    a.status = STAT_SKIPPED;
                else
                begin
                    last_prune = op.now;
                    keep_key.delete();
                    keep_expiry.delete();
                    keep_tag.delete();
                    for (int i = 0; i < TblSlots; i++)
                        if (shadow_state[i] == ST_USED && op.now <= shadow_expiry[i])
                        begin
                            keep_key.push_back(shadow_key[i]);
                            keep_expiry.push_back(shadow_expiry[i]);
                            keep_tag.push_back(shadow_tag[i]);
                        end
                    empty_table();
                    foreach (keep_key[i])
                        r = store_entry(keep_key[i], keep_expiry[i], keep_tag[i]);
                end
            end
            default:
            begin
            end
        endcase
        a.entry_count = live_count[13:0];
        return a;
    endfunction

    task automatic send_op(input op_t op);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {op.now, op.tag, op.expiry, op.key};
        s_axis_tuser <= op.kind;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_answers.push_back(table_answer(op));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(0, 12);
        end
    endtask

    task automatic do_op(input kind_t kind, input logic [31:0] key, input logic [31:0] expiry,
                         input logic [7:0] tag, input logic [31:0] now);
        op_t op;
        op = '{kind, key, expiry, tag, now};
        send_op(op);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_interval(input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        interval_reg = value;
    endtask

    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata[1:0], m_axis_tdata[2], m_axis_tdata[10:3],
                   m_axis_tdata[42:11], m_axis_tdata[56:43]};
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", got);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d hit %0d/%0d tag %h/%h exp %h/%h cnt %0d/%0d",
                                 want.status, got.status, want.hit, got.hit,
                                 want.found_tag, got.found_tag, want.found_expiry,
                                 got.found_expiry, want.entry_count, got.entry_count);
                end
            end
        end
    end

    // The receiver runs through calm, patchy, periodic and heavy stall phases.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cnt <= '0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 16'd1;
            case (stall_cnt[10:9])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= (stall_cnt[2:0] != 3'd0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic test_directed();
        do_op(KIND_FIND, 32'h0, 32'h0, 8'h0, 32'h0);
        do_op(KIND_INSERT, 32'h0, 32'h0, 8'h00, 32'hFFFFFFFF);
        do_op(KIND_INSERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'h0);
        do_op(KIND_FIND, 32'hFFFFFFFF, 32'h0, 8'h0, 32'h0);
        do_op(KIND_INSERT, 32'h0, 32'h12345678, 8'hA5, 32'h0);
        do_op(KIND_FIND, 32'h0, 32'h0, 8'h0, 32'h0);
        do_op(KIND_UPDATE, 32'h0, 32'h00000064, 8'h0, 32'h0);
        do_op(KIND_UPDATE, 32'h5555AAAA, 32'h1, 8'h0, 32'h0);
        do_op(KIND_ERASE, 32'h0, 32'h0, 8'h0, 32'h0);
        do_op(KIND_ERASE, 32'h0, 32'h0, 8'h0, 32'h0);
        do_op(KIND_FIND, 32'h0, 32'h0, 8'h0, 32'h0);
        do_op(KIND_NOP6, 32'hAAAA5555, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF);
        do_op(KIND_NOP7, 32'h5555AAAA, 32'h0, 8'h5A, 32'h0);
        do_op(KIND_INSERT, 32'h00010001, 32'd50, 8'h11, 32'h0);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, 32'd10);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, 32'd100);
        do_op(KIND_FIND, 32'h00010001, 32'h0, 8'h0, 32'h0);
        do_op(KIND_FIND, 32'hFFFFFFFF, 32'h0, 8'h0, 32'h0);
        do_op(KIND_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF);
        do_op(KIND_FIND, 32'hFFFFFFFF, 32'h0, 8'h0, 32'h0);
    endtask

    // Fills one probe window with keys of the same home slot until inserts drop.
    task automatic test_saturation();
        do_op(KIND_CLEAR, 32'h0, 32'h0, 8'h0, 32'h0);
        for (int i = 0; i <= ProbeMax; i++)
            do_op(KIND_INSERT, chain_keys[i], $urandom, 8'($urandom), $urandom);
        do_op(KIND_FIND, chain_keys[ProbeMax - 1], 32'h0, 8'h0, 32'h0);
        do_op(KIND_ERASE, chain_keys[10], 32'h0, 8'h0, 32'h0);
        do_op(KIND_FIND, chain_keys[40], 32'h0, 8'h0, 32'h0);
        do_op(KIND_INSERT, chain_keys[ProbeMax], 32'h77, 8'h77, 32'h0);
        do_op(KIND_INSERT, chain_keys[ProbeMax + 1], 32'h78, 8'h78, 32'h0);
        do_op(KIND_FIND, chain_keys[ProbeMax], 32'h0, 8'h0, 32'h0);
        for (int i = 0; i < 8; i++)
            do_op(KIND_ERASE, chain_keys[i * 3], 32'h0, 8'h0, 32'h0);
        for (int i = 0; i < 8; i++)
            do_op(KIND_FIND, chain_keys[$urandom_range(0, ProbeMax + 1)], 32'h0, 8'h0, 32'h0);
    endtask

    task automatic test_prune_interval();
        write_interval(16'hFFFF);
        clock_now = last_prune + 32'd100;
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, clock_now);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, last_prune + 32'h0000FFFF);
        write_interval(16'd0);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, last_prune);
        write_interval(16'd1);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, last_prune);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, 32'hFFFFFFFF);
        do_op(KIND_PRUNE, 32'h0, 32'h0, 8'h0, 32'h00000005);
        clock_now = 32'h00000005;
        write_interval(16'd90);
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned pick;
        op_t         op;
        for (int n = 0; n < count; n++)
        begin
            if (n % 400 == 399)
            begin
                case ($urandom_range(0, 3))
                    0: write_interval(16'd0);
                    1: write_interval(16'hFFFF);
                    2: write_interval(16'd90);
                    default: write_interval(16'($urandom_range(1, 600)));
                endcase
            end
            clock_now = clock_now + $urandom_range(0, 6);
            pick = $urandom_range(0, 9);
            op.key = (pick < 6) ? key_pool[$urandom_range(0, key_pool.size() - 1)]
                   : (pick < 8) ? chain_keys[$urandom_range(0, chain_keys.size() - 1)]
                   : $urandom;
            op.expiry = ($urandom_range(0, 9) == 0) ? $urandom
                      : clock_now + $urandom_range(0, 300);
            op.tag = 8'($urandom);
            op.now = ($urandom_range(0, 19) == 0) ? $urandom : clock_now;
            pick = $urandom_range(0, 999);
            op.kind = (pick < 320) ? KIND_FIND
                    : (pick < 640) ? KIND_INSERT
                    : (pick < 780) ? KIND_ERASE
                    : (pick < 950) ? KIND_UPDATE
                    : (pick < 955) ? KIND_CLEAR
                    : (pick < 970) ? KIND_PRUNE
                    : (pick < 985) ? KIND_NOP6 : KIND_NOP7;
            if (op.kind == KIND_PRUNE)
                op.now = clock_now;
            send_op(op);
        end
    endtask

    initial
    begin
        empty_table();
        last_prune = '0;
        interval_reg = PruneReset;
        mismatches = 0;
        burst_left = 0;
        clock_now = 32'd200;
        for (int i = 0; i < 48; i++)
            key_pool.push_back($urandom);
        for (logic [31:0] k = 32'h10000000; chain_keys.size() < ProbeMax + 2; k++)
            if (home_of(k) == TblSlots - 20)
                chain_keys.push_back(k);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        write_interval(16'd90);
        test_directed();
        test_saturation();
        test_prune_interval();
        test_random(1750);
        wait_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #100000000;
        $display("simulation failed");
        $finish;
    end

endmodule
